// ===== rtl/ihtab_pkg.sv =====
// ----------------------------------------------------------------------------
// ihtab_pkg: shared types and constants for the inode name hash table
// Table geometry, field widths, mode and status codes, and payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ihtab_pkg;

  // Table geometry; the home slot is the low key bits, so the size is a power of two
  localparam int unsigned TABLE_SIZE = 8192;
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned NAME_BYTES = 14;

  localparam int unsigned SLOT_W    = $clog2(TABLE_SIZE);
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned PARENT_W  = 16;
  localparam int unsigned NAME_LO_W = 64;
  localparam int unsigned NAME_HI_W = 48;
  localparam int unsigned DATA_W    = PARENT_W + NAME_LO_W + NAME_HI_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Masks for the used key bits and name bytes
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_BITS) - 64'd1);
  localparam logic [NAME_LO_W-1:0] NAME_LO_MASK =
    (NAME_BYTES >= 8) ? {NAME_LO_W{1'b1}}
                      : ((NAME_LO_W'(1) << (8 * NAME_BYTES)) - NAME_LO_W'(1));
  localparam logic [NAME_HI_W-1:0] NAME_HI_MASK =
    (NAME_BYTES <= 8) ? '0
                      : ((NAME_HI_W'(1) << (8 * (NAME_BYTES - 8))) - NAME_HI_W'(1));

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_RECORD = 2'd2
  } ihtab_mode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_DOT    = 2'd2,
    STAT_ABSENT = 2'd3
  } ihtab_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_DATA,
    ST_DONE
  } ihtab_state_e;

  typedef struct packed {
    logic [1:0]           mode;
    logic [KEY_W-1:0]     key;
    logic [PARENT_W-1:0]  parent;
    logic [NAME_LO_W-1:0] name_low;
    logic [NAME_HI_W-1:0] name_high;
  } ihtab_in_t;

  typedef struct packed {
    logic                 found;
    logic [SLOT_W-1:0]    slot;
    logic [PARENT_W-1:0]  stored_parent;
    logic [NAME_LO_W-1:0] stored_name_low;
    logic [NAME_HI_W-1:0] stored_name_high;
    ihtab_status_e        status;
  } ihtab_out_t;

  // Key store port: one write, one registered read per cycle
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic [SLOT_W-1:0] raddr;
  } ihtab_kreq_t;

  // Entry data store port: parent in the top bits, then name low, then name high
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } ihtab_dreq_t;

  // Name is "." or ".."
  function automatic logic is_dot_name(logic [NAME_LO_W-1:0] lo);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = lo[7:0];
    b1 = lo[15:8];
    b2 = lo[23:16];
    return (b0 == DOT_CHAR) && ((b1 == 8'h00) || ((b1 == DOT_CHAR) && (b2 == 8'h00)));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ihtab_key_ram.sv =====
// ----------------------------------------------------------------------------
// ihtab_key_ram: key store of the hash table
// One slot key per entry, zero marks an empty slot. Registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ihtab_key_ram (
  input  logic                      clk_i,
  input  ihtab_pkg::ihtab_kreq_t    req_i,
  output logic [ihtab_pkg::KEY_W-1:0] rdata_o
);
  import ihtab_pkg::*;

  logic [KEY_W-1:0] mem_q [TABLE_SIZE];
  logic [KEY_W-1:0] rdata_q;

  // Write one slot, read one slot
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ihtab_data_ram.sv =====
// ----------------------------------------------------------------------------
// ihtab_data_ram: entry data store of the hash table
// Parent inode and name per slot, written on insert and record. Registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ihtab_data_ram (
  input  logic                         clk_i,
  input  ihtab_pkg::ihtab_dreq_t       req_i,
  output logic [ihtab_pkg::DATA_W-1:0] rdata_o
);
  import ihtab_pkg::*;

  logic [DATA_W-1:0] mem_q [TABLE_SIZE];
  logic [DATA_W-1:0] rdata_q;

  // Write one entry, read one entry
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ihtab_seq.sv =====
// ----------------------------------------------------------------------------
// ihtab_seq: probe sequencer of the hash table
// Clears the key store after reset, walks the probe chain one slot per cycle
// with a single key comparator, then inserts, records or reports the entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ihtab_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ihtab_pkg::ihtab_in_t         in_data_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output ihtab_pkg::ihtab_out_t        res_o,
  output ihtab_pkg::ihtab_kreq_t       kreq_o,
  input  logic [ihtab_pkg::KEY_W-1:0]  key_rdata_i,
  output ihtab_pkg::ihtab_dreq_t       dreq_o,
  input  logic [ihtab_pkg::DATA_W-1:0] data_rdata_i
);
  import ihtab_pkg::*;

  ihtab_state_e      state_q, state_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] probes_q, probes_d;
  logic [SLOT_W-1:0] count_q, count_d;
  ihtab_in_t         item_q, item_d;
  ihtab_out_t        res_q, res_d;

  ihtab_in_t         in_masked;
  logic              absent;
  logic              has_empty;
  logic [SLOT_W-1:0] absent_slot;

  // Trim the incoming item to the used key bits and name bytes
  always_comb begin
    in_masked           = in_data_i;
    in_masked.key       = in_data_i.key & KEY_MASK;
    in_masked.name_low  = in_data_i.name_low & NAME_LO_MASK;
    in_masked.name_high = in_data_i.name_high & NAME_HI_MASK;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      count_q  <= '0;
      probes_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      count_q  <= count_d;
      probes_q <= probes_d;
    end
  end

  // Item, probe position and result
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    slot_q <= slot_d;
    res_q  <= res_d;
  end

  // Next state, store requests and result
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    probes_d    = probes_q;
    item_d      = item_q;
    slot_d      = slot_q;
    res_d       = res_q;
    kreq_o      = '0;
    kreq_o.raddr = slot_q;
    dreq_o      = '0;
    dreq_o.raddr = slot_q;
    absent      = 1'b0;
    has_empty   = 1'b0;
    absent_slot = slot_q;

    unique case (state_q)
      ST_CLEAR: begin
        // sweep the key store to empty, one slot per cycle
        kreq_o.we    = 1'b1;
        kreq_o.waddr = clr_q;
        kreq_o.wdata = '0;
        clr_d        = clr_q + SLOT_W'(1);
        if (clr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          item_d       = in_masked;
          slot_d       = in_masked.key[SLOT_W-1:0];
          probes_d     = '0;
          kreq_o.raddr = in_masked.key[SLOT_W-1:0];
          if (in_masked.key == '0) begin
            // zero key is never stored
            res_d        = '0;
            res_d.status = STAT_ABSENT;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_PROBE;
          end
        end
      end

      ST_PROBE: begin
        if (key_rdata_i == item_q.key) begin
          // hit: fetch the entry data
          dreq_o.raddr = slot_q;
          state_d      = ST_DATA;
        end else if (key_rdata_i == '0) begin
          absent    = 1'b1;
          has_empty = 1'b1;
        end else if (probes_q == LAST_SLOT) begin
          // every slot visited: absent at the home slot
          absent      = 1'b1;
          absent_slot = item_q.key[SLOT_W-1:0];
        end else begin
          // advance to the next slot, wrapping at the end
          slot_d       = slot_q + SLOT_W'(1);
          probes_d     = probes_q + SLOT_W'(1);
          kreq_o.raddr = slot_q + SLOT_W'(1);
        end

        if (absent) begin
          res_d       = '0;
          res_d.slot  = absent_slot;
          if (item_q.mode == MODE_INSERT) begin
            if (has_empty && (count_q != LAST_SLOT)) begin
              kreq_o.we    = 1'b1;
              kreq_o.waddr = absent_slot;
              kreq_o.wdata = item_q.key;
              dreq_o.we    = 1'b1;
              dreq_o.waddr = absent_slot;
              dreq_o.wdata = '0;
              count_d      = count_q + SLOT_W'(1);
              res_d.status = STAT_OK;
            end else begin
              res_d.status = STAT_FULL;
            end
          end else begin
            res_d.status = STAT_ABSENT;
          end
          state_d = ST_DONE;
        end
      end

      ST_DATA: begin
        res_d.found = 1'b1;
        res_d.slot  = slot_q;
        {res_d.stored_parent, res_d.stored_name_low, res_d.stored_name_high} = data_rdata_i;
        res_d.status = STAT_OK;
        if (item_q.mode == MODE_RECORD) begin
          if (is_dot_name(item_q.name_low)) begin
            res_d.status = STAT_DOT;
          end else begin
            // record parent and name into the entry
            dreq_o.we    = 1'b1;
            dreq_o.waddr = slot_q;
            dreq_o.wdata = {item_q.parent, item_q.name_low, item_q.name_high};
            res_d.stored_parent    = item_q.parent;
            res_d.stored_name_low  = item_q.name_low;
            res_d.stored_name_high = item_q.name_high;
          end
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // hold the result until the output register takes it
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/inode_name_hash_table.sv =====
// ----------------------------------------------------------------------------
// inode_name_hash_table: linear probing hash table of inode names
// Keyed by inode number; find or insert, lookup, and record parent and name.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o   | ihtab_in_t
//  out     | output    | out_valid_o / out_stall_i | ihtab_out_t
//
//  An item passes through the accept cycle, the key store reads (one probe
//  slot per cycle through the single key comparator), a data store read on
//  a hit, and the hand-off to the output. After reset the key store is
//  swept empty; no transfer is taken meanwhile. The output register lets a
//  new item start while a result waits under out_stall_i.
// ----------------------------------------------------------------------------
`default_nettype none

module inode_name_hash_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ihtab_pkg::ihtab_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ihtab_pkg::ihtab_out_t out_data_o
);
  import ihtab_pkg::*;

  ihtab_kreq_t       kreq;
  ihtab_dreq_t       dreq;
  logic [KEY_W-1:0]  key_rdata;
  logic [DATA_W-1:0] data_rdata;
  logic              res_valid;
  logic              res_ready;
  ihtab_out_t        res;

  logic              out_valid_q;
  ihtab_out_t        out_data_q;

  ihtab_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .kreq_o       (kreq),
    .key_rdata_i  (key_rdata),
    .dreq_o       (dreq),
    .data_rdata_i (data_rdata)
  );

  ihtab_key_ram u_key_ram (
    .clk_i   (clk_i),
    .req_i   (kreq),
    .rdata_o (key_rdata)
  );

  ihtab_data_ram u_data_ram (
    .clk_i   (clk_i),
    .req_i   (dreq),
    .rdata_o (data_rdata)
  );

  // Output register takes a result when empty or when its transfer completes
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== sim/inode_name_hash_table_test.sv =====
// ----------------------------------------------------------------------------
// inode_name_hash_table_test: self-checking bench for the inode hash table
// Drives find-or-insert, lookup and record requests through the valid/stall
// channels and compares each result with a table model kept in a scoreboard.
// Directed cases cover wrap-around, collisions, dot names and the zero key.
// Random traffic runs under varying idle rates. A final fill packs a run of
// slots across the wrap point so that probes walk long chains and wrap.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module inode_name_hash_table_test;
  import ihtab_pkg::*;

  localparam logic [1:0]           MODE_UNUSED = 2'd3;
  localparam logic [NAME_LO_W-1:0] NAME_DOT    = 64'h2E;
  localparam logic [NAME_LO_W-1:0] NAME_DOTDOT = 64'h2E2E;
  localparam logic [NAME_LO_W-1:0] NAME_DOTS3  = 64'h2E2E2E;
  localparam int unsigned          ITEMS_PER_PHASE = 420;
  localparam int unsigned          HOLD_OFF_CYCLES = 300;
  localparam int unsigned          TAIL_CYCLES     = 50;
  localparam int unsigned          FILL_RUN        = 40;
  localparam logic [SLOT_W-1:0]    CLUSTER_BASE    = SLOT_W'(TABLE_SIZE - 20);

  // Scoreboard: table model plus the queue of results still to arrive
  class inode_lookup_board;
    logic [KEY_W-1:0]     slot_key     [TABLE_SIZE];
    logic [PARENT_W-1:0]  slot_parent  [TABLE_SIZE];
    logic [NAME_LO_W-1:0] slot_name_lo [TABLE_SIZE];
    logic [NAME_HI_W-1:0] slot_name_hi [TABLE_SIZE];
    int unsigned          entry_count;
    logic [KEY_W-1:0]     known_keys[$];
    ihtab_out_t           awaited_lookups[$];
    int unsigned          mismatches;

    function new();
      foreach (slot_key[i]) begin
        slot_key[i]     = '0;
        slot_parent[i]  = '0;
        slot_name_lo[i] = '0;
        slot_name_hi[i] = '0;
      end
      entry_count = 0;
      mismatches  = 0;
    endfunction

    // Walk from the home slot; stop at the key or at the first empty slot
    function bit probe(input logic [KEY_W-1:0] key, output logic [SLOT_W-1:0] slot,
                       output bit empty_met);
      logic [SLOT_W-1:0] home;
      home      = key[SLOT_W-1:0];
      slot      = home;
      empty_met = 1'b0;
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (slot_key[slot] == '0) begin
          empty_met = 1'b1;
          return 1'b0;
        end
        if (slot_key[slot] == key) return 1'b1;
        slot = slot + SLOT_W'(1);
      end
      slot = home;
      return 1'b0;
    endfunction

    function bit holds_key(input logic [KEY_W-1:0] key);
      logic [SLOT_W-1:0] slot;
      bit                empty_met;
      return probe(key, slot, empty_met);
    endfunction

    // Apply one request to the model and return the result it should produce
    function ihtab_out_t predict_lookup(input ihtab_in_t item);
      ihtab_out_t           res;
      logic [KEY_W-1:0]     key;
      logic [NAME_LO_W-1:0] nlo;
      logic [NAME_HI_W-1:0] nhi;
      logic [SLOT_W-1:0]    slot;
      bit                   hit;
      bit                   empty_met;
      bit                   dot;
      key = item.key & KEY_MASK;
      nlo = item.name_low & NAME_LO_MASK;
      nhi = item.name_high & NAME_HI_MASK;
      res = '0;
      res.status = STAT_OK;
      if (key == '0) begin
        res.status = STAT_ABSENT;
        return res;
      end
      hit       = probe(key, slot, empty_met);
      res.found = hit;
      res.slot  = slot;
      dot = (nlo[7:0] == DOT_CHAR) &&
            ((nlo[15:8] == 8'h00) || ((nlo[15:8] == DOT_CHAR) && (nlo[23:16] == 8'h00)));
      if (hit) begin
        if (item.mode == MODE_RECORD) begin
          if (dot) begin
            res.status = STAT_DOT;
          end else begin
            slot_parent[slot]  = item.parent;
            slot_name_lo[slot] = nlo;
            slot_name_hi[slot] = nhi;
          end
        end
        res.stored_parent    = slot_parent[slot];
        res.stored_name_low  = slot_name_lo[slot];
        res.stored_name_high = slot_name_hi[slot];
      end else if (item.mode == MODE_INSERT) begin
        if (!empty_met || (entry_count + 1 >= TABLE_SIZE)) begin
          res.status = STAT_FULL;
        end else begin
          entry_count++;
          slot_key[slot]     = key;
          slot_parent[slot]  = '0;
          slot_name_lo[slot] = '0;
          slot_name_hi[slot] = '0;
          known_keys.push_back(key);
        end
      end else begin
        res.status = STAT_ABSENT;
      end
      return res;
    endfunction

    function void note_request(input ihtab_in_t item);
      awaited_lookups.push_back(predict_lookup(item));
    endfunction

    function string describe(input ihtab_out_t r);
      return $sformatf("found=%0d slot=%0d parent=%h name=%h_%h status=%0d",
                       r.found, r.slot, r.stored_parent, r.stored_name_high,
                       r.stored_name_low, r.status);
    endfunction

    // Compare one transfer from the output channel with the oldest expectation
    function void check_lookup(input ihtab_out_t got);
      ihtab_out_t want;
      if (awaited_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = awaited_lookups.pop_front();
      if (got.found !== want.found || got.slot !== want.slot ||
          got.stored_parent !== want.stored_parent ||
          got.stored_name_low !== want.stored_name_low ||
          got.stored_name_high !== want.stored_name_high ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t\n  expected %s\n  actual   %s",
                   $realtime, describe(want), describe(got));
      end
    endfunction

    function int unsigned pending();
      return awaited_lookups.size();
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  ihtab_in_t  in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  ihtab_out_t out_data_o;

  inode_lookup_board board;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_idle_pct  = 0;
  int unsigned       recv_hold_left = 0;

  inode_name_hash_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic ihtab_in_t make_item(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                                          input logic [PARENT_W-1:0] parent,
                                          input logic [NAME_LO_W-1:0] nlo,
                                          input logic [NAME_HI_W-1:0] nhi);
    ihtab_in_t item;
    item.mode      = mode;
    item.key       = key;
    item.parent    = parent;
    item.name_low  = nlo;
    item.name_high = nhi;
    return item;
  endfunction

  // Random name, biased toward dot names and near misses
  function automatic logic [NAME_LO_W-1:0] random_name_low();
    logic [NAME_LO_W-1:0] name;
    int unsigned          pick;
    name = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 8) begin
      name[15:0] = 16'h002E;
    end else if (pick < 16) begin
      name[23:0] = 24'h002E2E;
    end else if (pick < 22) begin
      name[15:0] = 16'h2E2E;
      if (name[23:16] == 8'h00) name[23:16] = 8'h01;
    end else if (pick < 26) begin
      name[7:0] = DOT_CHAR;
    end else if (pick < 30) begin
      name = (pick < 28) ? NAME_DOT : NAME_DOTDOT;
    end
    return name;
  endfunction

  function automatic logic [NAME_HI_W-1:0] random_name_high();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // A key with the given home slot that the table does not hold, or zero
  function automatic logic [KEY_W-1:0] absent_key_at(input logic [SLOT_W-1:0] home);
    logic [KEY_W-SLOT_W-1:0] upper;
    logic [KEY_W-1:0]        key;
    upper = (KEY_W - SLOT_W)'($urandom_range((1 << (KEY_W - SLOT_W)) - 1));
    for (int i = 0; i < (1 << (KEY_W - SLOT_W)); i++) begin
      key = {upper, home};
      if (key != '0 && !board.holds_key(key)) return key;
      upper = upper + (KEY_W - SLOT_W)'(1);
    end
    return '0;
  endfunction

  function automatic logic [KEY_W-1:0] random_known_key();
    return board.known_keys[$urandom_range(board.known_keys.size() - 1)];
  endfunction

  // Mixed random request: mostly keys that exist or collide, some noise
  function automatic ihtab_in_t random_request();
    ihtab_in_t        item;
    int unsigned      pick;
    logic [KEY_W-1:0] key;
    bit               have_known;
    have_known = board.known_keys.size() > 0;
    pick = $urandom_range(99);
    if (pick < 35)      item.mode = MODE_INSERT;
    else if (pick < 60) item.mode = MODE_LOOKUP;
    else if (pick < 93) item.mode = MODE_RECORD;
    else                item.mode = MODE_UNUSED;
    pick = $urandom_range(99);
    if (pick < 4) begin
      key = '0;
    end else if (pick < 45 && have_known) begin
      key = random_known_key();
    end else if (pick < 65 && have_known) begin
      key = random_known_key();
      key[KEY_W-1:SLOT_W] = (KEY_W - SLOT_W)'($urandom_range((1 << (KEY_W - SLOT_W)) - 1));
    end else if (pick < 75) begin
      key = {3'($urandom), 13'(TABLE_SIZE - 4 + $urandom_range(7))};
    end else begin
      key = 16'($urandom);
    end
    item.key       = key;
    item.parent    = 16'($urandom);
    item.name_low  = random_name_low();
    item.name_high = random_name_high();
    return item;
  endfunction

  // Offer one request and hold it until the block takes the transfer
  task automatic send_item(input ihtab_in_t item);
    @(negedge clk_i);
    while (roll(send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(item);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall, or a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (recv_hold_left > 0) begin
        out_stall_i <= 1'b1;
        recv_hold_left--;
      end else begin
        out_stall_i <= roll(recv_idle_pct);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_lookup(out_data_o);
  end

  initial begin
    logic [SLOT_W-1:0] run_slot;
    logic [KEY_W-1:0]  key;
    board = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: basic modes, dot names, zero key, wrap-around and collisions
    send_item(make_item(MODE_INSERT, 16'd1, '0, '0, '0));
    send_item(make_item(MODE_INSERT, 16'd1, '1, '1, '1));
    send_item(make_item(MODE_RECORD, 16'd1, '1, '1, '1));
    send_item(make_item(MODE_LOOKUP, 16'd1, '0, '0, '0));
    send_item(make_item(MODE_RECORD, 16'd1, 16'h1234, NAME_DOT, '1));
    send_item(make_item(MODE_RECORD, 16'd1, '0, NAME_DOTDOT, '0));
    send_item(make_item(MODE_RECORD, 16'd1, 16'h0001, NAME_DOTS3, 48'h1));
    send_item(make_item(MODE_RECORD, 16'd1, 16'h8000, 64'h412E, 48'h8000_0000_0000));
    send_item(make_item(MODE_UNUSED, 16'd1, '1, '1, '1));
    send_item(make_item(MODE_RECORD, 16'd1, '0, '0, '0));
    send_item(make_item(MODE_LOOKUP, 16'hFFFF, '0, '0, '0));
    send_item(make_item(MODE_RECORD, 16'd2, 16'h5555, 64'h6F6F_6E61_6D65, '0));
    send_item(make_item(MODE_INSERT, '0, '1, '1, '1));
    send_item(make_item(MODE_RECORD, '0, '1, 64'h4142, '1));
    send_item(make_item(MODE_LOOKUP, '0, '0, '0, '0));
    send_item(make_item(MODE_INSERT, 16'hFFFF, '0, '0, '0));
    send_item(make_item(MODE_INSERT, 16'h1FFF, '0, '0, '0));
    send_item(make_item(MODE_INSERT, 16'h2000, '0, '0, '0));
    send_item(make_item(MODE_LOOKUP, 16'h2000, '0, '0, '0));
    send_item(make_item(MODE_LOOKUP, 16'h4000, '0, '0, '0));
    send_item(make_item(MODE_RECORD, 16'h1FFF, 16'hA5A5, {8{8'h5A}}, '1));
    send_item(make_item(MODE_INSERT, 16'h1FFF, '0, '0, '0));
    send_item(make_item(MODE_UNUSED, 16'h4000, '0, '0, '0));
    wait_drained();

    // Random traffic, sender mostly busy and receiver mostly stalled
    send_idle_pct = 21;
    recv_idle_pct = 81;
    repeat (ITEMS_PER_PHASE) send_item(random_request());
    wait_drained();

    // Reverse idle rates; hold the receiver off so the input backs up
    send_idle_pct = 81;
    recv_idle_pct = 21;
    repeat (50) send_item(random_request());
    recv_hold_left = HOLD_OFF_CYCLES;
    repeat (ITEMS_PER_PHASE - 50) send_item(random_request());

    // No idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (ITEMS_PER_PHASE) send_item(random_request());

    // Pack a run of slots across the wrap point, each key at its home slot
    for (int i = 0; i < FILL_RUN; i++) begin
      run_slot = CLUSTER_BASE + SLOT_W'(i);
      if (board.slot_key[run_slot] == '0) begin
        key = absent_key_at(run_slot);
        send_item(make_item(MODE_INSERT, key, 16'($urandom), random_name_low(),
                            random_name_high()));
        if (roll(5))
          send_item(make_item(MODE_RECORD, key, 16'($urandom), random_name_low(),
                              random_name_high()));
      end
    end

    // Probes that start inside the run and walk past the wrap point
    send_item(make_item(MODE_LOOKUP, absent_key_at(CLUSTER_BASE), '0, '0, '0));
    send_item(make_item(MODE_RECORD, absent_key_at(CLUSTER_BASE + SLOT_W'(1)), '1, '1, '1));
    send_item(make_item(MODE_INSERT, absent_key_at(CLUSTER_BASE + SLOT_W'(3)), '1, '1, '1));
    send_item(make_item(MODE_INSERT, random_known_key(), '0, '0, '0));
    repeat (20) begin
      send_item(make_item(roll(50) ? MODE_RECORD : MODE_LOOKUP, random_known_key(),
                          16'($urandom), random_name_low(), random_name_high()));
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
